>>> rtl/atc_pkg.sv
// Package for the accelerometer tilt block: item types, cell buses,
// pipeline sizes and the arctangent table. No dependencies.
`default_nettype none

package atc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SQRT_STAGES   = 32;
	localparam int PIPE_LEN      = 2 + SQRT_STAGES + CORDIC_STAGES;
	localparam int DSQ_W         = 32;
	localparam int ROOT_W        = 32;
	localparam int REM_W         = 33;
	localparam int XY_W          = 35;
	localparam int ACC_W         = 25;
	localparam int ATAN_W        = 23;
	localparam int IDX_W         = 5;
	localparam int ANGLE_LIMIT   = 23040;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} accel_in_t;

	typedef struct packed {
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
	} tilt_out_t;

	typedef struct packed {
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
		logic [DSQ_W-1:0]   dsh;
		logic signed [15:0] num;
		logic               ok;
	} sqrt_bus_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ACC_W-1:0] acc;
		logic                    ok;
	} cordic_bus_t;

	// atan(2^-i) in degrees * 65536
	function automatic logic [ATAN_W-1:0] atan_deg16(input logic [IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:    v = 23'd2949120;
			5'd1:    v = 23'd1740967;
			5'd2:    v = 23'd919879;
			5'd3:    v = 23'd466945;
			5'd4:    v = 23'd234379;
			5'd5:    v = 23'd117304;
			5'd6:    v = 23'd58666;
			5'd7:    v = 23'd29335;
			5'd8:    v = 23'd14668;
			5'd9:    v = 23'd7334;
			5'd10:   v = 23'd3667;
			5'd11:   v = 23'd1833;
			5'd12:   v = 23'd917;
			5'd13:   v = 23'd458;
			5'd14:   v = 23'd229;
			5'd15:   v = 23'd115;
			5'd16:   v = 23'd57;
			5'd17:   v = 23'd29;
			5'd18:   v = 23'd14;
			5'd19:   v = 23'd7;
			5'd20:   v = 23'd4;
			5'd21:   v = 23'd2;
			5'd22:   v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/atc_sqrt_cell.sv
// One digit cell of the pipelined square root: settles one root bit.
// Depends on atc_pkg.
`default_nettype none

module atc_sqrt_cell (
	input  wire logic              clk,
	input  wire logic              run,
	input  wire atc_pkg::sqrt_bus_t din,
	output atc_pkg::sqrt_bus_t      dout
);
	import atc_pkg::*;

	logic [REM_W+1:0] rem2;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;
	sqrt_bus_t        nxt;
	sqrt_bus_t        bus_q;

	always_comb begin
		rem2  = {din.rem, din.dsh[DSQ_W-1 -: 2]};
		trial = {1'b0, din.root, 2'b01};
		diff  = rem2 - trial;
		ge    = (rem2 >= trial);
		nxt.dsh  = {din.dsh[DSQ_W-3:0], 2'b00};
		nxt.num  = din.num;
		nxt.ok   = din.ok;
		if (ge) begin
			nxt.rem  = diff[REM_W-1:0];
			nxt.root = {din.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem2[REM_W-1:0];
			nxt.root = {din.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			bus_q <= nxt;
		end
	end

	assign dout = bus_q;

endmodule

`default_nettype wire

>>> rtl/atc_cordic_cell.sv
// One vectoring CORDIC rotation cell, angle accumulated in degrees.
// Depends on atc_pkg (bus type and arctangent table).
`default_nettype none

module atc_cordic_cell (
	input  wire logic                 clk,
	input  wire logic                 run,
	input  wire logic [atc_pkg::IDX_W-1:0] idx,
	input  wire atc_pkg::cordic_bus_t din,
	output atc_pkg::cordic_bus_t      dout
);
	import atc_pkg::*;

	logic signed [XY_W-1:0]  dx;
	logic signed [XY_W-1:0]  dy;
	logic signed [ACC_W-1:0] at;
	cordic_bus_t             nxt;
	cordic_bus_t             bus_q;

	always_comb begin
		dx = din.y >>> idx;
		dy = din.x >>> idx;
		at = signed'({{(ACC_W-ATAN_W){1'b0}}, atan_deg16(idx)});
		nxt.ok = din.ok;
		if (!din.y[XY_W-1]) begin
			nxt.x   = din.x + dx;
			nxt.y   = din.y - dy;
			nxt.acc = din.acc + at;
		end else begin
			nxt.x   = din.x - dx;
			nxt.y   = din.y + dy;
			nxt.acc = din.acc - at;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			bus_q <= nxt;
		end
	end

	assign dout = bus_q;

endmodule

`default_nettype wire

>>> rtl/accel_tilt_angles.sv
// Top level of the accelerometer tilt block: squares, square-root and
// CORDIC cell rows, output skid. Depends on atc_pkg and both cell modules.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one sample
//   (accel_x, accel_y, accel_z). Output channel out_valid / out_stall /
//   out_data carries pitch_deg and roll_deg, degrees * 256.
//   cfg_we / cfg_wdata write min_magnitude; write only while idle.
//   Throughput: one item per cycle while in_stall is low. In each such
//   cycle every cell row moves one step: 2 front stages, 32 square-root
//   digit cells, 16 CORDIC cells, then the output register.
//   A two-entry output register/skid parts the sides: with the receiver
//   stalled the pipe keeps moving until both entries are full, then
//   in_stall goes high and the whole pipe holds.
//   Reset clears all valid bits and sets min_magnitude to 0.
`default_nettype none

module accel_tilt_angles (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire atc_pkg::accel_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output atc_pkg::tilt_out_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata
);
	import atc_pkg::*;

	logic [DSQ_W-1:0]     thr_q;
	logic [PIPE_LEN-1:0]  vld_q;
	logic                 run;

	logic signed [31:0]   xx_full, yy_full, zz_full;
	logic signed [15:0]   ax_s1, ay_s1;
	logic [30:0]          xx_s1, yy_s1, zz_s1;

	logic signed [15:0]   ax_s2, ay_s2;
	logic [DSQ_W-1:0]     dp_s2, dr_s2;
	logic                 pok_s2, rok_s2;

	sqrt_bus_t            sq_p [SQRT_STAGES+1];
	sqrt_bus_t            sq_r [SQRT_STAGES+1];
	cordic_bus_t          co_p [CORDIC_STAGES+1];
	cordic_bus_t          co_r [CORDIC_STAGES+1];

	tilt_out_t            res;
	tilt_out_t            o_q, s_q;
	logic                 o_vld_q, s_vld_q;
	logic                 take;
	logic                 pv;

	function automatic logic signed [15:0] final_angle(input cordic_bus_t b);
		logic signed [ACC_W-1:0] rnd;
		logic signed [ACC_W-9:0] r;
		logic signed [ACC_W-9:0] lim;
		logic signed [15:0]      v;
		lim = (ACC_W-8)'(ANGLE_LIMIT);
		rnd = b.acc + ACC_W'(128);
		r   = rnd[ACC_W-1:8];
		if (!b.ok) begin
			v = '0;
		end else if (r > lim) begin
			v = 16'(ANGLE_LIMIT);
		end else if (r < -lim) begin
			v = -16'(ANGLE_LIMIT);
		end else begin
			v = r[15:0];
		end
		return v;
	endfunction

	assign run      = !s_vld_q;
	assign in_stall = s_vld_q;

	// threshold kept squared: d > min_magnitude^2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= DSQ_W'(cfg_wdata) * DSQ_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (run) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], in_valid};
		end
	end

	assign xx_full = 32'(in_data.accel_x) * 32'(in_data.accel_x);
	assign yy_full = 32'(in_data.accel_y) * 32'(in_data.accel_y);
	assign zz_full = 32'(in_data.accel_z) * 32'(in_data.accel_z);

	always_ff @(posedge clk) begin
		if (run) begin
			ax_s1  <= in_data.accel_x;
			ay_s1  <= in_data.accel_y;
			xx_s1  <= xx_full[30:0];
			yy_s1  <= yy_full[30:0];
			zz_s1  <= zz_full[30:0];
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			dp_s2  <= {1'b0, yy_s1} + {1'b0, zz_s1};
			dr_s2  <= {1'b0, xx_s1} + {1'b0, zz_s1};
			pok_s2 <= ({1'b0, yy_s1} + {1'b0, zz_s1}) > thr_q;
			rok_s2 <= ({1'b0, xx_s1} + {1'b0, zz_s1}) > thr_q;
		end
	end

	assign sq_p[0] = '{rem: '0, root: '0, dsh: dp_s2, num: ax_s2, ok: pok_s2};
	assign sq_r[0] = '{rem: '0, root: '0, dsh: dr_s2, num: ay_s2, ok: rok_s2};

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		atc_sqrt_cell u_p (.clk(clk), .run(run), .din(sq_p[k]), .dout(sq_p[k+1]));
		atc_sqrt_cell u_r (.clk(clk), .run(run), .din(sq_r[k]), .dout(sq_r[k+1]));
	end

	assign co_p[0] = '{
		x:   signed'({{(XY_W-ROOT_W){1'b0}}, sq_p[SQRT_STAGES].root}),
		y:   signed'({{(XY_W-32){sq_p[SQRT_STAGES].num[15]}}, sq_p[SQRT_STAGES].num, 16'h0}),
		acc: '0,
		ok:  sq_p[SQRT_STAGES].ok
	};
	assign co_r[0] = '{
		x:   signed'({{(XY_W-ROOT_W){1'b0}}, sq_r[SQRT_STAGES].root}),
		y:   signed'({{(XY_W-32){sq_r[SQRT_STAGES].num[15]}}, sq_r[SQRT_STAGES].num, 16'h0}),
		acc: '0,
		ok:  sq_r[SQRT_STAGES].ok
	};

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
		atc_cordic_cell u_p (
			.clk(clk), .run(run), .idx(IDX_W'(j)), .din(co_p[j]), .dout(co_p[j+1])
		);
		atc_cordic_cell u_r (
			.clk(clk), .run(run), .idx(IDX_W'(j)), .din(co_r[j]), .dout(co_r[j+1])
		);
	end

	assign res.pitch_deg = final_angle(co_p[CORDIC_STAGES]);
	assign res.roll_deg  = final_angle(co_r[CORDIC_STAGES]);
	assign pv            = vld_q[PIPE_LEN-1];
	assign take          = o_vld_q && !out_stall;

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
			s_vld_q <= 1'b0;
		end else if (s_vld_q) begin
			if (take) begin
				s_vld_q <= 1'b0;
			end
		end else if (!o_vld_q || take) begin
			o_vld_q <= pv;
		end else if (pv) begin
			s_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_vld_q) begin
			if (take) begin
				o_q <= s_q;
			end
		end else if (!o_vld_q || take) begin
			o_q <= res;
		end else begin
			s_q <= res;
		end
	end

	assign out_valid = o_vld_q;
	assign out_data  = o_q;

endmodule

`default_nettype wire

>>> rtl/atc_checker.sv
// Port-level checks for accel_tilt_angles and the bind that attaches them.
// Depends on atc_pkg.
`default_nettype none

module atc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire atc_pkg::accel_in_t in_data,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire atc_pkg::tilt_out_t out_data
);
	import atc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output item changed");

	// stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input item changed");

	// input stalls only with both output entries full after a receiver stall
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && $past(out_stall))
		else $error("input stall without output backpressure");

	// input stall clears only when an output item was taken
	a_in_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> $past(out_valid && !out_stall))
		else $error("input stall released without output transfer");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(out_data.pitch_deg) <= 16'sd23040
			&& $signed(out_data.pitch_deg) >= -16'sd23040
			&& $signed(out_data.roll_deg) <= 16'sd23040
			&& $signed(out_data.roll_deg) >= -16'sd23040)
		else $error("angle out of range");

endmodule

bind accel_tilt_angles atc_checker u_atc_checker (.*);

`default_nettype wire

>>> dv/accel_tilt_angles_test.sv
// Self-checking bench for accel_tilt_angles: bursty sample traffic, receiver stalls,
// threshold changes between phases and a scoreboard that predicts pitch and roll.
// Depends on atc_pkg and the accel_tilt_angles RTL.
`timescale 1ns / 100ps

module accel_tilt_angles_test;
	import atc_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	class tilt_scoreboard;
		tilt_out_t   expected_q[$];
		logic [15:0] threshold;
		int          errors;
		int          samples;
		int          results;
		int          zeroed;

		function new();
			threshold = '0;
			errors    = 0;
			samples   = 0;
			results   = 0;
			zeroed    = 0;
		endfunction

		function void set_threshold(logic [15:0] v);
			threshold = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// atan(2^-i), degrees * 65536
		function longint signed atan_step(int i);
			case (i)
				0:  return 2949120;
				1:  return 1740967;
				2:  return 919879;
				3:  return 466945;
				4:  return 234379;
				5:  return 117304;
				6:  return 58666;
				7:  return 29335;
				8:  return 14668;
				9:  return 7334;
				10: return 3667;
				11: return 1833;
				12: return 917;
				13: return 458;
				14: return 229;
				15: return 115;
				16: return 57;
				17: return 29;
				18: return 14;
				19: return 7;
				20: return 4;
				21: return 2;
				22: return 1;
				default: return 0;
			endcase
		endfunction

		function longint unsigned floor_root(longint unsigned n);
			longint unsigned root;
			longint unsigned probe;
			root  = 0;
			probe = 64'd1 << 62;
			while (probe > n)
				probe = probe >> 2;
			while (probe != 0) begin
				if (n >= root + probe) begin
					n    = n - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			return root;
		endfunction

		// atan2(num, sqrt(dsq)) in degrees * 256, clamped to ANGLE_LIMIT; 0 if dsq <= threshold^2
		function longint signed tilt_of(longint signed num, longint unsigned dsq);
			longint unsigned lim;
			longint signed   cx, cy, acc, shx, shy, r;
			int              stages;
			lim = longint'(threshold) * longint'(threshold);
			if (dsq <= lim) begin
				zeroed++;
				return 0;
			end
			stages = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
			cx  = longint'(floor_root(dsq << 32));
			cy  = num * 65536;
			acc = 0;
			for (int i = 0; i < stages; i++) begin
				shx = cy >>> i;
				shy = cx >>> i;
				if (cy >= 0) begin
					cx  = cx + shx;
					cy  = cy - shy;
					acc = acc + atan_step(i);
				end else begin
					cx  = cx - shx;
					cy  = cy + shy;
					acc = acc - atan_step(i);
				end
			end
			r = (acc + 128) >>> 8;
			if (r > ANGLE_LIMIT)
				r = ANGLE_LIMIT;
			if (r < -ANGLE_LIMIT)
				r = -ANGLE_LIMIT;
			return r;
		endfunction

		function void note_sample(accel_in_t s);
			longint signed   ax, ay, az, p, q;
			longint unsigned xx, yy, zz;
			tilt_out_t       e;
			ax = $signed(s.accel_x);
			ay = $signed(s.accel_y);
			az = $signed(s.accel_z);
			xx = ax * ax;
			yy = ay * ay;
			zz = az * az;
			p  = tilt_of(ax, yy + zz);
			q  = tilt_of(ay, xx + zz);
			e.pitch_deg = p[15:0];
			e.roll_deg  = q[15:0];
			expected_q.push_back(e);
			samples++;
		endfunction

		function void check_result(tilt_out_t got);
			tilt_out_t e;
			results++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item pitch %0d roll %0d", $time,
					got.pitch_deg, got.roll_deg);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.pitch_deg !== e.pitch_deg) begin
				$display("%0t: pitch_deg expected %0d actual %0d", $time,
					e.pitch_deg, got.pitch_deg);
				errors++;
			end
			if (got.roll_deg !== e.roll_deg) begin
				$display("%0t: roll_deg expected %0d actual %0d", $time,
					e.roll_deg, got.roll_deg);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	accel_in_t   in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	tilt_out_t   out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	tilt_scoreboard sb = new();
	int unsigned    cyc = 0;
	int             quiet = 0;
	int             settings = 0;

	accel_tilt_angles dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// receiver stall pattern: free, light, heavy, periodic
	always @(posedge clk) begin
		cyc++;
		case (cyc[10:9])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((cyc % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic accel_in_t mk(int x, int y, int z);
		accel_in_t s;
		s.accel_x = x[15:0];
		s.accel_y = y[15:0];
		s.accel_z = z[15:0];
		return s;
	endfunction

	function automatic accel_in_t random_sample();
		int unsigned mode;
		int          v[3];
		int          t;
		mode = $urandom_range(0, 3);
		for (int k = 0; k < 3; k++) begin
			case (mode)
				0: v[k] = $urandom;
				1: v[k] = int'($urandom_range(0, 256)) - 128;
				2: v[k] = int'($urandom_range(0, 4000)) - 2000;
				default: begin
					case ($urandom_range(0, 5))
						0: v[k] = -32768;
						1: v[k] = 32767;
						2: v[k] = -1;
						3: v[k] = 0;
						4: v[k] = 1;
						default: v[k] = -32767;
					endcase
				end
			endcase
		end
		// gravity mostly along one axis
		if (mode == 2) begin
			t = 16384 + int'($urandom_range(0, 4000)) - 2000;
			v[$urandom_range(0, 2)] = $urandom_range(0, 1) ? t : -t;
		end
		return mk(v[0], v[1], v[2]);
	endfunction

	task automatic send_sample(input accel_in_t s);
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic idle_for(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(v);
		settings++;
	endtask

	task automatic send_random(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst) send_sample(random_sample());
			left -= burst;
			if ($urandom_range(0, 24) == 0)
				wait_drained();
			else if ($urandom_range(0, 2) == 0)
				idle_for($urandom_range(1, 12));
		end
	endtask

	initial begin
		int unsigned thr;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings = 1;

		// reset threshold: only a zero denominator is forced to zero
		send_sample(mk(0, 0, 0));
		send_sample(mk(-32768, -32768, -32768));
		send_sample(mk(32767, 32767, 32767));
		send_sample(mk(32767, 0, 0));
		send_sample(mk(-32768, 0, 0));
		send_sample(mk(0, 32767, 0));
		send_sample(mk(0, -32768, 0));
		send_sample(mk(0, 0, 32767));
		send_sample(mk(0, 0, -32768));
		send_sample(mk(1, 0, 0));
		send_sample(mk(0, -1, 0));
		send_sample(mk(1, 1, 1));
		send_sample(mk(-1, -1, -1));
		send_sample(mk(32767, -32768, 0));
		send_sample(mk(-32768, 32767, 1));
		send_sample(mk(0, 0, 1));
		send_sample(mk(16384, -16384, 16384));
		wait_drained();

		// denominator at and just above the threshold
		write_threshold(16'd5);
		send_sample(mk(4, 3, 4));
		send_sample(mk(4, 3, 5));
		send_sample(mk(-3, -4, 0));
		send_sample(mk(7, 3, 4));
		send_sample(mk(0, 0, 5));
		send_sample(mk(6, 0, 0));
		send_random(250);
		wait_drained();

		// largest threshold: every angle is zero
		write_threshold(16'd46341);
		send_sample(mk(-32768, -32768, -32768));
		send_sample(mk(32767, 32767, 32767));
		send_sample(mk(-32768, 0, 0));
		send_sample(mk(0, 32767, -32768));
		send_random(60);
		wait_drained();

		repeat (4) begin
			thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 46341)
				: $urandom_range(0, 120);
			write_threshold(thr[15:0]);
			send_random(180);
			wait_drained();
		end

		write_threshold(16'd0);
		send_random(120);
		wait_drained();
		repeat (PIPE_LEN + 8) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("Checked %0d samples (%0d results) over %0d threshold settings;",
			sb.samples, sb.results, settings);
		$display("%0d angles fell under the threshold, %0d mismatches.",
			sb.zeroed, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
